[rtl/sbx_pkg.sv]
// ----------------------------------------------------------------------------
// SBX crossover package
// Shared widths, constants and the elaboration-time root table for the
// power-of-two pipeline.
// ----------------------------------------------------------------------------
package sbx_pkg;

	localparam int RAND_W    = 16;          // random fraction, Q0.16
	localparam int CFG_W     = 17;          // 1/(eta+1), Q0.16 up to 1.0
	localparam int FRAC_W    = 30;          // Q.30 fraction bits
	localparam int LOG_FRAC  = 28;          // log2 fraction bits
	localparam int LOG_STEPS = 28;          // one squaring per fraction bit
	localparam int POW_STEPS = 30;          // one root multiply per fraction bit
	localparam int LOG_W     = 32;          // Q4.28 log value
	localparam int MANT_W    = 31;          // Q1.30 mantissa, below 2.0
	localparam int T_W       = 35;          // exponent magnitude, Q5.30
	localparam int IP_W      = 5;
	localparam int SH_W      = 6;
	localparam int BETA_W    = 61;          // spread factor, Q31.30

	localparam logic [CFG_W-1:0]  INV_ETA_RESET = 17'd3121;
	localparam logic [RAND_W:0]   FRAC_HALF     = 17'd32768;
	localparam logic [RAND_W:0]   FRAC_ONE      = 17'd65536;
	localparam logic [LOG_W-1:0]  LOG_SPAN      = 32'd15 << LOG_FRAC;
	localparam logic [MANT_W-1:0] MANT_ONE      = 31'd1 << FRAC_W;

	// 2^(2^-k) in Q1.30 by repeated floor square roots starting from 2.0
	function automatic logic [MANT_W-1:0] pow2_root(input int k);
		logic [63:0] root;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		root = 64'd1 << 31;
		for (int i = 1; i <= POW_STEPS; i++) begin
			if (i <= k) begin
				v   = root << 30;
				res = 64'd0;
				bt  = 64'd1 << 62;
				for (int j = 0; j < 32; j++) begin
					if (v >= res + bt) begin
						v   = v - (res + bt);
						res = (res >> 1) + bt;
					end else begin
						res = res >> 1;
					end
					bt = bt >> 2;
				end
				root = res;
			end
		end
		return root[MANT_W-1:0];
	endfunction

endpackage

[rtl/sbx_log2_pipe.sv]
// ----------------------------------------------------------------------------
// SBX log2 pipeline
// Normalizes a 16-bit magnitude and extracts 28 fraction bits of its base-2
// logarithm, one squaring of the mantissa per stage.
// ----------------------------------------------------------------------------
module sbx_log2_pipe
	import sbx_pkg::*;
#(
	parameter int SB_W = 1
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAND_W-1:0] mag,
	input  logic [SB_W-1:0]   side_in,
	output logic              out_vld,
	output logic [LOG_W-1:0]  log_val,
	output logic [SB_W-1:0]   side_out
);

	logic                     v_s   [LOG_STEPS+1];
	logic [MANT_W-1:0]        y_s   [LOG_STEPS+1];
	logic [LOG_W-1:0]         acc_s [LOG_STEPS+1];
	logic [SB_W-1:0]          sb_s  [LOG_STEPS+1];

	logic [3:0]               top_bit;
	logic [RAND_W+FRAC_W-1:0] norm;

	always_comb begin
		top_bit = 4'd0;
		for (int i = 0; i < RAND_W; i++) begin
			if (mag[i]) begin
				top_bit = 4'(i);
			end
		end
		norm = {mag, {FRAC_W{1'b0}}} >> top_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0]   <= norm[MANT_W-1:0];
			acc_s[0] <= {top_bit, {LOG_FRAC{1'b0}}};
			sb_s[0]  <= side_in;
		end
	end

	for (genvar i = 0; i < LOG_STEPS; i++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     sq_hi;
		logic [LOG_W-1:0]    acc_nxt;

		assign sq    = y_s[i] * y_s[i];
		assign sq_hi = sq[FRAC_W+MANT_W:FRAC_W];

		always_comb begin
			acc_nxt = acc_s[i];
			acc_nxt[LOG_FRAC-1-i] = sq_hi[MANT_W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		// renormalize when the square reached 2.0
		always_ff @(posedge clk) begin
			if (en) begin
				y_s[i+1]   <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
				acc_s[i+1] <= acc_nxt;
				sb_s[i+1]  <= sb_s[i];
			end
		end
	end

	assign out_vld  = v_s[LOG_STEPS];
	assign log_val  = acc_s[LOG_STEPS];
	assign side_out = sb_s[LOG_STEPS];

endmodule

[rtl/sbx_pow2_pipe.sv]
// ----------------------------------------------------------------------------
// SBX pow2 pipeline
// Computes 2^g for a Q0.30 fraction g, one conditional multiply by a
// constant root per stage, rounding half up in Q1.30.
// ----------------------------------------------------------------------------
module sbx_pow2_pipe
	import sbx_pkg::*;
#(
	parameter int SB_W = 1
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [FRAC_W-1:0] frac,
	input  logic [SB_W-1:0]   side_in,
	output logic              out_vld,
	output logic [MANT_W-1:0] pow_val,
	output logic [SB_W-1:0]   side_out
);

	logic              v_s  [POW_STEPS];
	logic [MANT_W-1:0] p_s  [POW_STEPS];
	logic [FRAC_W-1:0] g_s  [POW_STEPS];
	logic [SB_W-1:0]   sb_s [POW_STEPS];

	for (genvar i = 0; i < POW_STEPS; i++) begin : g_mul
		localparam logic [MANT_W-1:0] ROOT = pow2_root(i + 1);

		logic              v_prev;
		logic [MANT_W-1:0] p_prev;
		logic [FRAC_W-1:0] g_prev;
		logic [SB_W-1:0]   sb_prev;
		logic [2*MANT_W:0] prod;

		if (i == 0) begin : g_head
			assign v_prev  = in_vld;
			assign p_prev  = MANT_ONE;
			assign g_prev  = frac;
			assign sb_prev = side_in;
		end else begin : g_body
			assign v_prev  = v_s[i-1];
			assign p_prev  = p_s[i-1];
			assign g_prev  = g_s[i-1];
			assign sb_prev = sb_s[i-1];
		end

		assign prod = (2*MANT_W+1)'(p_prev * ROOT) + ((2*MANT_W+1)'(1) << (FRAC_W - 1));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[i]  <= g_prev[FRAC_W-1-i] ? prod[FRAC_W+MANT_W-1:FRAC_W] : p_prev;
				g_s[i]  <= g_prev;
				sb_s[i] <= sb_prev;
			end
		end
	end

	assign out_vld  = v_s[POW_STEPS-1];
	assign pow_val  = p_s[POW_STEPS-1];
	assign side_out = sb_s[POW_STEPS-1];

endmodule

[rtl/sbx_child_calc.sv]
// ----------------------------------------------------------------------------
// SBX child calculation
// Multiplies the spread factor by the parent distance in 32-bit partial
// products, forms both children with round half up and saturates them.
// ----------------------------------------------------------------------------
module sbx_child_calc
	import sbx_pkg::*;
#(
	parameter int DATA_WIDTH = 32
)(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [BETA_W-1:0]            beta,
	input  logic signed [DATA_WIDTH-1:0] lo,
	input  logic signed [DATA_WIDTH-1:0] hi,
	input  logic                         eq,
	output logic                         out_vld,
	output logic signed [DATA_WIDTH-1:0] child_lo,
	output logic signed [DATA_WIDTH-1:0] child_hi,
	output logic                         clip
);

	localparam int D_CHUNKS = (DATA_WIDTH + 31) / 32;
	localparam int B_CHUNKS = (BETA_W + 31) / 32;
	localparam int DPAD_W   = D_CHUNKS * 32;
	localparam int BPAD_W   = B_CHUNKS * 32;
	localparam int ACC_W    = DPAD_W + BPAD_W;
	localparam int PROD_W   = BETA_W + DATA_WIDTH;
	localparam int SUM_W    = PROD_W + 2;
	localparam int RES_W    = SUM_W - 31;
	localparam logic [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// stage 1: partial products
	logic [DATA_WIDTH-1:0] span;
	logic [DPAD_W-1:0]     dist_pad;
	logic [BPAD_W-1:0]     beta_pad;

	logic                  v_s1;
	logic [63:0]           pp_s1 [B_CHUNKS][D_CHUNKS];
	logic [DATA_WIDTH:0]   sum_s1;
	logic [DATA_WIDTH-1:0] lo_s1;
	logic                  eq_s1;

	assign span     = hi - lo;
	assign dist_pad = DPAD_W'(span);
	assign beta_pad = BPAD_W'(beta);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < B_CHUNKS; i++) begin
				for (int j = 0; j < D_CHUNKS; j++) begin
					pp_s1[i][j] <= beta_pad[32*i +: 32] * dist_pad[32*j +: 32];
				end
			end
			sum_s1 <= {lo[DATA_WIDTH-1], lo} + {hi[DATA_WIDTH-1], hi};
			lo_s1  <= lo;
			eq_s1  <= eq;
		end
	end

	// stage 2: sum the partial products
	logic [ACC_W-1:0]      acc;
	logic                  v_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic [DATA_WIDTH:0]   sum_s2;
	logic [DATA_WIDTH-1:0] lo_s2;
	logic                  eq_s2;

	always_comb begin
		acc = '0;
		for (int i = 0; i < B_CHUNKS; i++) begin
			for (int j = 0; j < D_CHUNKS; j++) begin
				acc = acc + (ACC_W'(pp_s1[i][j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= acc[PROD_W-1:0];
			sum_s2  <= sum_s1;
			lo_s2   <= lo_s1;
			eq_s2   <= eq_s1;
		end
	end

	// stage 3: midpoint minus and plus the spread, round half up
	logic [SUM_W-1:0]      base;
	logic [SUM_W-1:0]      sprod;
	logic [SUM_W-1:0]      low_sum;
	logic [SUM_W-1:0]      high_sum;
	logic                  v_s3;
	logic [RES_W-1:0]      low_s3;
	logic [RES_W-1:0]      high_s3;
	logic [DATA_WIDTH-1:0] lo_s3;
	logic                  eq_s3;

	assign base     = {{(SUM_W-DATA_WIDTH-1){sum_s2[DATA_WIDTH]}}, sum_s2} << FRAC_W;
	assign sprod    = {2'b00, prod_s2};
	assign low_sum  = base - sprod + (SUM_W'(1) << FRAC_W);
	assign high_sum = base + sprod + (SUM_W'(1) << FRAC_W);

	always_ff @(posedge clk) begin
		if (en) begin
			low_s3  <= low_sum[SUM_W-1:31];
			high_s3 <= high_sum[SUM_W-1:31];
			lo_s3   <= lo_s2;
			eq_s3   <= eq_s2;
		end
	end

	// stage 4: saturate
	logic [RES_W-DATA_WIDTH:0] low_top;
	logic [RES_W-DATA_WIDTH:0] high_top;
	logic                      low_fits;
	logic                      high_fits;
	logic [DATA_WIDTH-1:0]     low_sat;
	logic [DATA_WIDTH-1:0]     high_sat;
	logic                      v_s4;
	logic [DATA_WIDTH-1:0]     child_lo_s4;
	logic [DATA_WIDTH-1:0]     child_hi_s4;
	logic                      clip_s4;

	assign low_top   = low_s3[RES_W-1:DATA_WIDTH-1];
	assign high_top  = high_s3[RES_W-1:DATA_WIDTH-1];
	assign low_fits  = (&low_top) || (~|low_top);
	assign high_fits = (&high_top) || (~|high_top);
	assign low_sat   = low_fits ? low_s3[DATA_WIDTH-1:0]
	                            : (low_s3[RES_W-1] ? D_MIN : D_MAX);
	assign high_sat  = high_fits ? high_s3[DATA_WIDTH-1:0]
	                             : (high_s3[RES_W-1] ? D_MIN : D_MAX);

	always_ff @(posedge clk) begin
		if (en) begin
			// equal parents pass through untouched
			child_lo_s4 <= eq_s3 ? lo_s3 : low_sat;
			child_hi_s4 <= eq_s3 ? lo_s3 : high_sat;
			clip_s4     <= !eq_s3 && !(low_fits && high_fits);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_vld  = v_s4;
	assign child_lo = child_lo_s4;
	assign child_hi = child_hi_s4;
	assign clip     = clip_s4;

endmodule

[rtl/sbx_gene_crossover.sv]
// ----------------------------------------------------------------------------
// SBX gene crossover
// Simulated binary crossover of one gene pair per item, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one gene pair and delivers its two children; throughput is one
// item per cycle while in_stall is low. The pipeline holds the log2 unit
// (one mantissa squaring per stage, 29 stages), the pow2 unit (one root
// multiply per stage, 30 stages) and the four-stage child multiplier. A
// skid register behind the output register absorbs one item when
// out_stall rises; in_stall follows it and freezes the whole pipeline
// until the held item drains. The spread exponent register may be written
// at any time the pipeline is empty; cfg_ready is always high.
module sbx_gene_crossover
	import sbx_pkg::*;
#(
	parameter int DATA_WIDTH = 32
)(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] parent_a,
	input  logic signed [DATA_WIDTH-1:0] parent_b,
	input  logic [RAND_W-1:0]            rand_frac,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] child_low,
	output logic signed [DATA_WIDTH-1:0] child_high,
	output logic                         clipped,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_W-1:0]             inv_eta_plus_one
);

	typedef struct packed {
		logic [DATA_WIDTH-1:0] lo;
		logic [DATA_WIDTH-1:0] hi;
		logic                  eq;
		logic [RAND_W-1:0]     r;
	} log_side_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] lo;
		logic [DATA_WIDTH-1:0] hi;
		logic                  eq;
		logic                  upper;
		logic                  rzero;
		logic [IP_W-1:0]       ip;
		logic [SH_W-1:0]       sh;
	} pow_side_t;

	logic en;
	logic skid_vld_q;
	logic out_vld_q;

	assign en        = !skid_vld_q;
	assign in_stall  = skid_vld_q;
	assign cfg_ready = 1'b1;

	// configuration
	logic [CFG_W-1:0] inv_eta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_eta_q <= INV_ETA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inv_eta_q <= inv_eta_plus_one;
		end
	end

	// order the parents and fold u about one half
	log_side_t         side_in;
	logic              a_less;
	logic [RAND_W:0]   fold;
	logic [RAND_W-1:0] mag;

	assign a_less     = parent_a < parent_b;
	assign side_in.lo = a_less ? parent_a : parent_b;
	assign side_in.hi = a_less ? parent_b : parent_a;
	assign side_in.eq = parent_a == parent_b;
	assign side_in.r  = rand_frac;
	assign fold       = FRAC_ONE - {1'b0, rand_frac};
	assign mag        = ({1'b0, rand_frac} <= FRAC_HALF) ? rand_frac : fold[RAND_W-1:0];

	logic             log_vld;
	logic [LOG_W-1:0] log_val;
	log_side_t        log_side;

	sbx_log2_pipe #(
		.SB_W ($bits(log_side_t))
	) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.mag      (mag),
		.side_in  (side_in),
		.out_vld  (log_vld),
		.log_val  (log_val),
		.side_out (log_side)
	);

	// scale the log magnitude by the exponent
	logic [LOG_W-1:0]       log_mag;
	logic [CFG_W+LOG_W-1:0] t_prod;
	logic                   v_s1;
	logic [T_W-1:0]         t_s1;
	log_side_t              side_s1;

	assign log_mag = LOG_SPAN - log_val;
	assign t_prod  = inv_eta_q * log_mag;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_prod[T_W+13:14];
			side_s1 <= log_side;
		end
	end

	// split into integer and fraction, pick the pow2 argument
	logic [IP_W-1:0]   ip;
	logic [FRAC_W-1:0] f;
	logic [FRAC_W:0]   f_inv;
	logic              upper;
	pow_side_t         pside;
	logic [FRAC_W-1:0] g;
	logic              v_s2;
	logic [FRAC_W-1:0] g_s2;
	pow_side_t         side_s2;

	assign ip     = t_s1[T_W-1:FRAC_W];
	assign f      = t_s1[FRAC_W-1:0];
	assign f_inv  = (FRAC_W+1)'(MANT_ONE) - {1'b0, f};
	assign upper  = {1'b0, side_s1.r} > FRAC_HALF;

	always_comb begin
		pside.lo    = side_s1.lo;
		pside.hi    = side_s1.hi;
		pside.eq    = side_s1.eq;
		pside.upper = upper;
		pside.rzero = side_s1.r == '0;
		pside.ip    = ip;
		pside.sh    = {1'b0, ip};
		g           = f;
		// below one half the exponent is negative: 2^-(ip+f) = 2^(1-f) / 2^(ip+1)
		if (!upper && f != '0) begin
			g        = f_inv[FRAC_W-1:0];
			pside.sh = {1'b0, ip} + SH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2    <= g;
			side_s2 <= pside;
		end
	end

	logic              pow_vld;
	logic [MANT_W-1:0] pow_val;
	pow_side_t         pow_side;

	sbx_pow2_pipe #(
		.SB_W ($bits(pow_side_t))
	) u_pow2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s2),
		.frac     (g_s2),
		.side_in  (side_s2),
		.out_vld  (pow_vld),
		.pow_val  (pow_val),
		.side_out (pow_side)
	);

	// spread factor: zero for a zero fraction, shift up for the upper half, round-shift down otherwise
	logic [MANT_W:0]       rnd;
	logic [MANT_W:0]       rsum;
	logic [MANT_W:0]       rquo;
	logic [BETA_W-1:0]     beta;
	logic                  v_s3;
	logic [BETA_W-1:0]     beta_s3;
	logic [DATA_WIDTH-1:0] lo_s3;
	logic [DATA_WIDTH-1:0] hi_s3;
	logic                  eq_s3;

	assign rnd  = (pow_side.sh == '0) ? '0 : ((MANT_W+1)'(1) << (pow_side.sh - SH_W'(1)));
	assign rsum = {1'b0, pow_val} + rnd;
	assign rquo = rsum >> pow_side.sh;

	always_comb begin
		if (pow_side.rzero) begin
			beta = '0;
		end else if (pow_side.upper) begin
			beta = BETA_W'(pow_val) << pow_side.ip;
		end else begin
			beta = BETA_W'(rquo);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beta_s3 <= beta;
			lo_s3   <= pow_side.lo;
			hi_s3   <= pow_side.hi;
			eq_s3   <= pow_side.eq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= log_vld;
			v_s2 <= v_s1;
			v_s3 <= pow_vld;
		end
	end

	logic                         c_vld;
	logic signed [DATA_WIDTH-1:0] c_lo;
	logic signed [DATA_WIDTH-1:0] c_hi;
	logic                         c_clip;

	sbx_child_calc #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_child (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.beta     (beta_s3),
		.lo       (lo_s3),
		.hi       (hi_s3),
		.eq       (eq_s3),
		.out_vld  (c_vld),
		.child_lo (c_lo),
		.child_hi (c_hi),
		.clip     (c_clip)
	);

	// output register with one skid entry
	logic [DATA_WIDTH-1:0] child_low_q;
	logic [DATA_WIDTH-1:0] child_high_q;
	logic                  clipped_q;
	logic [DATA_WIDTH-1:0] skid_low_q;
	logic [DATA_WIDTH-1:0] skid_high_q;
	logic                  skid_clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= c_vld;
			end
		end else if (en && c_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				child_low_q  <= skid_low_q;
				child_high_q <= skid_high_q;
				clipped_q    <= skid_clip_q;
			end else begin
				child_low_q  <= c_lo;
				child_high_q <= c_hi;
				clipped_q    <= c_clip;
			end
		end else if (en && c_vld) begin
			skid_low_q  <= c_lo;
			skid_high_q <= c_hi;
			skid_clip_q <= c_clip;
		end
	end

	assign out_valid  = out_vld_q;
	assign child_low  = child_low_q;
	assign child_high = child_high_q;
	assign clipped    = clipped_q;

	localparam logic signed [DATA_WIDTH-1:0] S_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] S_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	a_skid_only_behind_held: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds an item while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && out_stall))
		else $error("skid filled without a stalled output");

	a_children_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> child_low <= child_high)
		else $error("child_low above child_high");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (child_low == S_MIN || child_low == S_MAX ||
			child_high == S_MIN || child_high == S_MAX))
		else $error("clipped set with no child at a range limit");

endmodule

[sim/tb_sbx_gene_crossover.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SBX gene crossover testbench
// Streams gene pairs through the crossover block under several spread
// exponents and idle patterns, predicts both children and the clip flag in
// fixed point, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_sbx_gene_crossover;
	import sbx_pkg::*;

	localparam int DW         = 32;
	localparam int WATCHDOG   = 20000;
	localparam int DRAIN_WAIT = 100;
	localparam int LONG_HOLD  = 400;

	typedef struct {
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic [RAND_W-1:0]    r;
	} gene_t;

	typedef struct {
		logic signed [DW-1:0] low;
		logic signed [DW-1:0] high;
		logic                 clip;
	} children_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [DW-1:0] parent_a;
	logic signed [DW-1:0] parent_b;
	logic [RAND_W-1:0] rand_frac;
	logic out_valid;
	logic out_stall;
	logic signed [DW-1:0] child_low;
	logic signed [DW-1:0] child_high;
	logic clipped;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] inv_eta_plus_one;

	gene_t       pending_genes[$];
	children_t   expected_children[$];
	logic [63:0] root_tab[1:30];
	logic [CFG_W-1:0] exp_reg;
	int send_idle_pct;
	int stall_pct;
	int mismatches;
	int idle_cycles;
	logic long_hold_req;
	logic long_hold_done;
	int hold_left;

	sbx_gene_crossover #(.DATA_WIDTH(DW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.parent_a(parent_a), .parent_b(parent_b), .rand_frac(rand_frac),
		.out_valid(out_valid), .out_stall(out_stall),
		.child_low(child_low), .child_high(child_high), .clipped(clipped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.inv_eta_plus_one(inv_eta_plus_one)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^g, g in Q0.30, result in Q1.30
	function automatic logic [63:0] exp2_frac(input logic [63:0] g);
		logic [63:0] p;
		p = 64'd1 << 30;
		for (int k = 1; k <= 30; k++)
			if (g[30-k])
				p = (p * root_tab[k] + (64'd1 << 29)) >> 30;
		return p;
	endfunction

	function automatic logic [63:0] log2_fix(input logic [63:0] m);
		int k;
		logic [63:0] y;
		logic [63:0] fr;
		k  = 0;
		fr = 0;
		while ((m >> (k + 1)) != 0)
			k++;
		y = m << (30 - k);
		for (int i = 0; i < LOG_FRAC; i++) begin
			y  = (y * y) >> 30;
			fr = fr << 1;
			if (y >= (64'd1 << 31)) begin
				y     = y >> 1;
				fr[0] = 1'b1;
			end
		end
		return (64'(k) << LOG_FRAC) | fr;
	endfunction

	function automatic logic [63:0] round_shift(input logic [63:0] v, input int s);
		if (s == 0)
			return v;
		if (s >= 63)
			return 0;
		return (v + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic logic [63:0] spread_factor(input logic [63:0] r, input logic [63:0] e);
		logic [63:0] m;
		logic [63:0] t;
		logic [63:0] f;
		int ip;
		if (r == 0)
			return 0;
		m  = (r <= 32768) ? r : 65536 - r;
		t  = (e * ((64'd15 << LOG_FRAC) - log2_fix(m))) >> 14;
		ip = int'(t >> 30);
		f  = t & ((64'd1 << 30) - 1);
		if (r > 32768)
			return exp2_frac(f) << ip;
		if (f == 0)
			return round_shift(64'd1 << 30, ip);
		return round_shift(exp2_frac((64'd1 << 30) - f), ip + 1);
	endfunction

	function automatic logic signed [DW-1:0] clamp_child(input logic signed [127:0] v,
			inout logic clip);
		logic signed [127:0] maxv;
		logic signed [127:0] minv;
		maxv = 128'sd2147483647;
		minv = -128'sd2147483648;
		if (v > maxv) begin
			clip = 1'b1;
			return 32'h7fffffff;
		end
		if (v < minv) begin
			clip = 1'b1;
			return 32'h80000000;
		end
		return v[DW-1:0];
	endfunction

	function automatic children_t crossover(input gene_t g, input logic [CFG_W-1:0] e);
		children_t c;
		logic signed [DW-1:0] lo;
		logic signed [DW-1:0] hi;
		logic [63:0] beta;
		logic [63:0] d;
		logic signed [127:0] base;
		logic signed [127:0] prod;
		logic [127:0] uprod;
		c.clip = 1'b0;
		if (g.a == g.b) begin
			c.low  = g.a;
			c.high = g.b;
			return c;
		end
		lo   = (g.a < g.b) ? g.a : g.b;
		hi   = (g.a < g.b) ? g.b : g.a;
		d    = 64'(longint'(hi) - longint'(lo));
		beta = spread_factor(64'(g.r), 64'(e));
		base = lo;
		base = (base + hi) <<< 30;
		uprod = {64'd0, beta} * {64'd0, d};
		prod  = uprod;
		c.low  = clamp_child((base - prod + (128'sd1 <<< 30)) >>> 31, c.clip);
		c.high = clamp_child((base + prod + (128'sd1 <<< 30)) >>> 31, c.clip);
		return c;
	endfunction

	function automatic logic signed [DW-1:0] rand_parent();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2, 3: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			default: return $urandom;
		endcase
	endfunction

	function automatic gene_t rand_gene();
		gene_t g;
		g.a = rand_parent();
		case ($urandom_range(0, 9))
			0: g.b = g.a;
			1: g.b = g.a + $signed($urandom_range(0, 8)) - 4;
			default: g.b = rand_parent();
		endcase
		case ($urandom_range(0, 9))
			0: g.r = 16'(32768 + $urandom_range(0, 2) - 1);
			1: g.r = 16'($urandom_range(0, 3));
			2: g.r = 16'(65535 - $urandom_range(0, 3));
			default: g.r = 16'($urandom);
		endcase
		return g;
	endfunction

	task automatic push_gene(input logic [31:0] a, input logic [31:0] b, input int r);
		gene_t g;
		g.a = a;
		g.b = b;
		g.r = 16'(r);
		pending_genes.push_back(g);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_genes.size() != 0 || in_valid || expected_children.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_exponent(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid        <= 1'b1;
		inv_eta_plus_one <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		exp_reg = v;
	endtask

	task automatic push_random(input int n);
		repeat (n) pending_genes.push_back(rand_gene());
	endtask

	// driver: predict on accept, then offer the next pending item
	always @(posedge clk) begin
		gene_t g;
		if (in_valid && !in_stall) begin
			g.a = parent_a;
			g.b = parent_b;
			g.r = rand_frac;
			expected_children.push_back(crossover(g, exp_reg));
		end
		if (!in_valid || !in_stall) begin
			if (pending_genes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				g = pending_genes.pop_front();
				parent_a  <= g.a;
				parent_b  <= g.b;
				rand_frac <= g.r;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare results and drive the output stall
	always @(posedge clk) begin
		children_t c;
		if (out_valid && !out_stall) begin
			if (expected_children.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: low=%0d high=%0d clip=%0b",
						child_low, child_high, clipped);
			end else begin
				c = expected_children.pop_front();
				if (c.low !== child_low || c.high !== child_high || c.clip !== clipped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp low=%0d high=%0d clip=%0b, got %0d %0d %0b",
							c.low, c.high, c.clip, child_low, child_high, clipped);
				end
			end
		end
		if (long_hold_req && !long_hold_done && hold_left == 0) begin
			hold_left      = LONG_HOLD;
			long_hold_done <= 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb_sbx_gene_crossover: errors");
			$finish;
		end
	end

	initial begin
		logic [63:0] root;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		parent_a         = '0;
		parent_b         = '0;
		rand_frac        = '0;
		out_stall        = 1'b0;
		cfg_valid        = 1'b0;
		inv_eta_plus_one = INV_ETA_RESET;
		exp_reg          = INV_ETA_RESET;
		send_idle_pct    = 0;
		stall_pct        = 0;
		mismatches       = 0;
		idle_cycles      = 0;
		long_hold_req    = 1'b0;
		long_hold_done   = 1'b0;
		hold_left        = 0;
		root = 64'd1 << 31;
		for (int k = 1; k <= 30; k++) begin
			root        = floor_sqrt(root << 30);
			root_tab[k] = root;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, equal parents, order, zero and boundary fractions
		push_gene(32'h7fffffff, 32'h80000000, 65535);
		push_gene(32'h80000000, 32'h7fffffff, 1);
		push_gene(32'h80000000, 32'h7fffffff, 32768);
		push_gene(32'h7fffffff, 32'h80000000, 32769);
		push_gene(32'h12345678, 32'h12345678, 40000);
		push_gene(32'h80000000, 32'h80000000, 65535);
		push_gene(32'h00010000, 32'h00030000, 0);
		push_gene(32'h00030000, 32'h00010000, 0);
		push_gene(32'h00010000, 32'h00030000, 16384);
		push_gene(32'h00030000, 32'h00010000, 49152);
		push_gene(32'hffffffff, 32'h00000000, 65535);
		push_gene(32'h00000000, 32'h00000001, 32768);
		push_gene(32'h40000000, 32'h7fffffff, 65535);
		push_gene(32'hc0000000, 32'h80000000, 65000);
		push_gene(32'hffff0000, 32'h00010000, 12345);
		wait_drained();

		// reset exponent, no idling; then long receiver hold with sender offering
		push_random(150);
		wait_drained();
		long_hold_req = 1'b1;
		push_random(150);
		wait_drained();

		write_exponent('0);
		send_idle_pct = 87;
		push_random(100);
		push_gene(32'h7fffffff, 32'h80000000, 65535);
		push_gene(32'h80000000, 32'h7fffffff, 1);
		wait_drained();

		write_exponent(CFG_W'(65536));
		send_idle_pct = 0;
		stall_pct     = 87;
		push_random(150);
		wait_drained();

		write_exponent(CFG_W'(131071));
		send_idle_pct = 9;
		stall_pct     = 9;
		push_random(150);
		// sender pauses here until all results are back
		wait_drained();
		push_random(100);
		wait_drained();

		write_exponent(CFG_W'(1));
		send_idle_pct = 0;
		stall_pct     = 0;
		push_random(100);
		wait_drained();

		write_exponent(CFG_W'($urandom_range(1, 131071)));
		send_idle_pct = 9;
		stall_pct     = 9;
		push_random(150);
		wait_drained();

		if (mismatches == 0)
			$display("tb_sbx_gene_crossover: clean");
		else
			$display("tb_sbx_gene_crossover: errors");
		$finish;
	end

endmodule
